### rtl/obbp_pkg.sv
// obbp_pkg: shared widths, table geometry and entry layout for the one-bit
// branch predictor. No dependencies; used by the top level and its checker.
package obbp_pkg;

  localparam int INDEX_BITS  = 10;
  localparam int DEPTH       = 1 << INDEX_BITS;
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 32;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = ADDR_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 + 3 * CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic              dir;
  } entry_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

### rtl/one_bit_branch_predictor.sv
// one_bit_branch_predictor: tagged one-bit branch history table with
// saturating hit, miss and collision counters. Depends on obbp_pkg.
//
// Usage:
//   in channel (in_tvalid/in_tready/in_tdata) carries one branch per
//   transaction: its address and its resolved outcome. out channel carries
//   one result per branch: the prediction read before the update, whether
//   it was right, whether the tag collided, and the three running counts.
//   A branch passes through the s1 stage and the result register; one
//   branch per cycle is accepted while out_tready is high. The table
//   lives in a 1024-entry memory with a registered read, one read and
//   one write port; the branch ahead's entry is forwarded to the next.
//   After reset the block clears all 1024 entries, one entry per cycle,
//   with in_tready low; the counters start at zero.
//   When the receiver stalls, the result register holds its transaction,
//   the stage behind it fills, and then in_tready drops until out_tready
//   returns.
module one_bit_branch_predictor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] branch_address, [32] taken, rest zero
  input  logic [obbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] predicted_taken, [1] prediction_right, [2] was_collision,
  // [34:3] right_count, [66:35] wrong_count, [98:67] collision_count
  output logic [obbp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  obbp_pkg::entry_t mem [obbp_pkg::DEPTH];

  logic                       clearing_r;
  obbp_pkg::idx_t             clr_idx_r;

  logic                       s1_valid_r;
  logic [obbp_pkg::ADDR_W-1:0] s1_addr_r;
  logic                       s1_taken_r;
  obbp_pkg::entry_t           rd_r;

  logic                       lw_valid_r;
  obbp_pkg::idx_t             lw_idx_r;
  obbp_pkg::entry_t           lw_data_r;

  obbp_pkg::cnt_t             hits_r, hits_nxt;
  obbp_pkg::cnt_t             misses_r, misses_nxt;
  obbp_pkg::cnt_t             clashes_r, clashes_nxt;

  logic                       out_valid_r;
  logic [obbp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                       in_fire;
  logic                       s1_adv;
  obbp_pkg::idx_t             in_idx;
  obbp_pkg::idx_t             s1_idx;
  obbp_pkg::entry_t           cur;
  obbp_pkg::entry_t           new_entry;
  logic                       guess;
  logic                       right;
  logic                       clash;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;
  assign in_idx    = in_tdata[obbp_pkg::INDEX_BITS-1:0];
  assign s1_idx    = s1_addr_r[obbp_pkg::INDEX_BITS-1:0];

  always_comb begin
    // the read may have missed the write of the branch just ahead
    cur       = (lw_valid_r && lw_idx_r == s1_idx) ? lw_data_r : rd_r;
    clash     = cur.tag != s1_addr_r;
    guess     = cur.dir;
    right     = guess == s1_taken_r;
    // a misprediction takes the outcome, a right guess already equals it
    new_entry = '{tag: s1_addr_r, dir: s1_taken_r};

    hits_nxt    = (right && !clash) ? obbp_pkg::sat_inc(hits_r) : hits_r;
    misses_nxt  = (!right && !clash) ? obbp_pkg::sat_inc(misses_r) : misses_r;
    clashes_nxt = clash ? obbp_pkg::sat_inc(clashes_r) : clashes_r;

    out_data_nxt = '0;
    out_data_nxt[0] = guess;
    out_data_nxt[1] = right;
    out_data_nxt[2] = clash;
    out_data_nxt[3 +: obbp_pkg::CNT_W] = hits_nxt;
    out_data_nxt[3 + obbp_pkg::CNT_W +: obbp_pkg::CNT_W] = misses_nxt;
    out_data_nxt[3 + 2 * obbp_pkg::CNT_W +: obbp_pkg::CNT_W] = clashes_nxt;
  end

  // table memory: one write port shared by clearing and updates
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (s1_adv) begin
      mem[s1_idx] <= new_entry;
    end
    if (in_fire) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      clashes_r   <= '0;
    end else begin
      if (clearing_r) begin
        if (clr_idx_r == '1) begin
          clearing_r <= 1'b0;
        end
        clr_idx_r <= clr_idx_r + obbp_pkg::idx_t'(1);
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        lw_valid_r  <= 1'b1;
        out_valid_r <= 1'b1;
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        clashes_r   <= clashes_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r  <= in_tdata[obbp_pkg::ADDR_W-1:0];
      s1_taken_r <= in_tdata[obbp_pkg::ADDR_W];
    end
    if (s1_adv) begin
      lw_idx_r   <= s1_idx;
      lw_data_r  <= new_entry;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/obbp_checker.sv
// obbp_checker: port-level assertions for one_bit_branch_predictor, bound
// to the top level below. Depends on obbp_pkg.
module obbp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [obbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [obbp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // table clearing keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input open or result shown right after reset");

  // a collision always leaves a nonzero collision count
  a_clash_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |->
      out_tdata[3 + 2 * obbp_pkg::CNT_W +: obbp_pkg::CNT_W] != '0)
    else $error("collision reported with zero collision count");

  // a fresh result comes from an input accepted through the s1 stage and result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind one_bit_branch_predictor obbp_checker u_obbp_checker (.*);
